// ===== rtl/ept_pkg.sv =====
// Shared constants for the encoder period-average tachometer.
// Ring geometry, divider numerator and register indexes; no dependencies.
package ept_pkg;

  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Period sum: RING_DEPTH entries of 16 bits.
  localparam int SUM_W = $clog2(RING_DEPTH * 65535 + 1);
  localparam int PPR_W = 12;
  localparam int GR_W  = 16;
  localparam int GAP_W = 16;
  localparam int STL_W = 20;
  localparam int P1_W  = SUM_W + PPR_W;
  localparam int DEN_W = P1_W + GR_W;

  // 60e6 * RING_DEPTH * 256 (Q8 result) * 256 (Q8.8 ratio).
  localparam logic [63:0] RPM_NUM = 64'd60000000 * 64'(RING_DEPTH) * 64'd65536;
  localparam int NUM_W  = $clog2(RPM_NUM + 64'd1);
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 20;
  localparam logic [CFG_IW-1:0] CFG_PPR   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RATIO = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GAP   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_STALE = 2'd3;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

// ===== rtl/ept_if.sv =====
// Valid/ready channel interfaces for the tachometer.
// Input carries events, output carries speed results; no dependencies.
interface ept_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_us;

  modport source (output valid, op, now_us, input ready);
  modport sink   (input valid, op, now_us, output ready);
endinterface

interface ept_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rpm_q8;
  logic        average_ready;

  modport source (output valid, rpm_q8, average_ready, input ready);
  modport sink   (input valid, rpm_q8, average_ready, output ready);
endinterface

// ===== rtl/ept_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ept_ram #(
  parameter int W = 16,
  parameter int D = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic                             re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ept_div.sv =====
// Restoring divider, one quotient bit per cycle: RPM_NUM / den, saturated
// to 32 bits. Depends on ept_pkg.
module ept_div
  import ept_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic              zero_r, zero_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = RPM_NUM[NUM_W-1:0];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  // Saturate on a zero divisor or a quotient wider than 32 bits.
  assign quo  = (zero_r || (|q_r[NUM_W-1:32])) ? 32'hFFFF_FFFF : q_r[31:0];

endmodule

// ===== rtl/encoder_period_average_tachometer.sv =====
// Encoder period-average tachometer, top level.
// A speed read, a restarting edge or an edge that leaves the ring unfilled goes
// through S_UPD and S_OUT. An edge that updates the speed also passes S_MUL1,
// S_MUL2 and the divider (S_DIV); one item is in flight at a time.
// Synchronous active-low reset restores register defaults and clears the
// ring valid bits, pointer, sum, speed and last edge time; no clearing pass.
module encoder_period_average_tachometer
  import ept_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  ept_in_if.sink            in_ch,
  ept_out_if.source         out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [PPR_W-1:0]    ppr_r;
  logic [GR_W-1:0]     ratio_r;
  logic [GAP_W-1:0]    gap_r;
  logic [STL_W-1:0]    stale_r;

  logic                op_r;
  logic [31:0]         now_r;
  logic [31:0]         elapsed_r;
  logic [31:0]         last_r, last_nxt;
  logic [RING_AW-1:0]  ptr_r, ptr_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                full_r, full_nxt;
  logic [31:0]         speed_r, speed_nxt;
  logic [RING_DEPTH-1:0] vld_r, vld_nxt;
  logic [P1_W-1:0]     prod1_r;

  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_rpm_r;
  logic                out_avg_r;

  logic                accept;
  logic                ram_we;
  logic [15:0]         ram_rdata;
  logic [15:0]         prev_period;
  logic                div_done;
  logic [31:0]         div_quo;
  logic [DEN_W-1:0]    den;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign prev_period = vld_r[ptr_r] ? ram_rdata : 16'd0;
  assign den         = DEN_W'(prod1_r) * DEN_W'(ratio_r);

  ept_ram #(.W(16), .D(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (elapsed_r[15:0]),
    .re    (accept),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  ept_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MUL2),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    full_nxt      = full_r;
    speed_nxt     = speed_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_OUT;
        if (op_r == OP_READ) begin
          if (elapsed_r > {12'd0, stale_r}) begin
            speed_nxt = '0;
          end
        end else if (elapsed_r > {16'd0, gap_r}) begin
          // Restart averaging; keep ring contents, sum and speed.
          full_nxt = 1'b0;
          ptr_nxt  = '0;
          last_nxt = now_r;
        end else begin
          ram_we         = 1'b1;
          vld_nxt[ptr_r] = 1'b1;
          sum_nxt  = sum_r - SUM_W'(prev_period) + SUM_W'(elapsed_r[15:0]);
          last_nxt = now_r;
          if (ptr_r == RING_AW'(RING_DEPTH - 1)) begin
            ptr_nxt = '0;
          end else begin
            ptr_nxt = ptr_r + RING_AW'(1);
          end
          if (full_r || (ptr_r == RING_AW'(RING_DEPTH - 1))) begin
            full_nxt  = 1'b1;
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          speed_nxt = div_quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ppr_r       <= PPR_W'(1);
      ratio_r     <= GR_W'(256);
      gap_r       <= GAP_W'(10000);
      stale_r     <= STL_W'(15000);
      last_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      full_r      <= 1'b0;
      speed_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      full_r      <= full_nxt;
      speed_r     <= speed_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PPR:   ppr_r   <= cfg_wdata[PPR_W-1:0];
          CFG_RATIO: ratio_r <= cfg_wdata[GR_W-1:0];
          CFG_GAP:   gap_r   <= cfg_wdata[GAP_W-1:0];
          CFG_STALE: stale_r <= cfg_wdata[STL_W-1:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      op_r      <= in_ch.op;
      now_r     <= in_ch.now_us;
      elapsed_r <= in_ch.now_us - last_r;
    end
    if (state_r == S_MUL1) begin
      prod1_r <= P1_W'(sum_r) * P1_W'(ppr_r);
    end
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_rpm_r <= speed_r;
      out_avg_r <= full_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rpm_q8        = out_rpm_r;
  assign out_ch.average_ready = out_avg_r;

endmodule
